/* rtl/imudr_pkg.sv */
// Shared types, constants and helper functions for the inertial dead-reckoning step.
// Used by imudr_core and imu_dead_reckoning_step; depends on nothing.
`default_nettype none

package imudr_pkg;

	typedef logic signed [55:0] wide_t;
	typedef logic signed [31:0] q32_t;
	typedef logic signed [15:0] s16_t;

	// Q16 scale factors: 0.9, 0.1 (filter) and 0.1 (step time).
	localparam logic signed [21:0] K_KEEP = 22'sd58982;
	localparam logic signed [21:0] K_NEW  = 22'sd6554;
	localparam logic signed [21:0] K_DT   = 22'sd6554;

	// Configuration register indexes.
	localparam logic [2:0] CFG_CAL_X     = 3'd0;
	localparam logic [2:0] CFG_CAL_Y     = 3'd1;
	localparam logic [2:0] CFG_CAL_Z     = 3'd2;
	localparam logic [2:0] CFG_GATE_STR  = 3'd3;
	localparam logic [2:0] CFG_STILL_TOL = 3'd4;

	typedef struct packed {
		s16_t        cal_x;
		s16_t        cal_y;
		s16_t        cal_z;
		logic [15:0] gate_strength;
		logic [14:0] still_tolerance;
	} cfg_t;

	typedef struct packed {
		s16_t accel_x;
		s16_t accel_y;
		s16_t accel_z;
		s16_t quat_w;
		s16_t quat_x;
		s16_t quat_y;
		s16_t quat_z;
	} sample_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	function automatic q32_t sat32(input wide_t v);
		if (v > 56'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -56'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic wide_t mag(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

endpackage

`default_nettype wire

/* rtl/imudr_mul.sv */
// Shared signed multiplier with a registered product.
// Stand-alone; used by imudr_core for every product of the step.
`default_nettype none

module imudr_mul (
	input  wire logic               clk,
	input  wire logic signed [34:0] a,
	input  wire logic signed [21:0] b,
	output logic signed [56:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

/* rtl/imudr_core.sv */
// Sequencer and datapath of the dead-reckoning step: filter, gate, velocity, push.
// Depends on imudr_pkg and drives one imudr_mul instance.
`default_nettype none

module imudr_core import imudr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire sample_t sample,
	input  wire cfg_t    cfg,
	input  wire logic    out_free,
	output stat_t        stat,
	output q32_t         pos_x,
	output q32_t         pos_y,
	output q32_t         pos_z
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_A0   = 5'd1;
	localparam logic [4:0] ST_A1   = 5'd2;
	localparam logic [4:0] ST_A2   = 5'd3;
	localparam logic [4:0] ST_A3   = 5'd4;
	localparam logic [4:0] ST_B0   = 5'd5;
	localparam logic [4:0] ST_B1   = 5'd6;
	localparam logic [4:0] ST_C0   = 5'd7;
	localparam logic [4:0] ST_C1   = 5'd8;
	localparam logic [4:0] ST_C2   = 5'd9;
	localparam logic [4:0] ST_C3   = 5'd10;
	localparam logic [4:0] ST_C4   = 5'd11;
	localparam logic [4:0] ST_C5   = 5'd12;
	localparam logic [4:0] ST_C6   = 5'd13;
	localparam logic [4:0] ST_C7   = 5'd14;
	localparam logic [4:0] ST_C8   = 5'd15;
	localparam logic [4:0] ST_C9   = 5'd16;
	localparam logic [4:0] ST_OUT  = 5'd17;

	logic [4:0] step_q;
	logic [1:0] ax_q;

	s16_t s_q [3];
	s16_t qw_q, qx_q, qy_q, qz_q;
	q32_t filt_q [3];
	q32_t gat_q  [3];
	q32_t prev_q [3];
	q32_t vel_q  [3];
	q32_t pos_q  [3];
	logic signed [32:0] force_q [3];
	logic signed [21:0] fwd_q   [3];
	q32_t  fn_q;
	wide_t acc_q;
	wide_t b_q;

	logic signed [34:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [56:0] prod_q;

	imudr_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	wide_t p56, s_cur, cal_cur, sum_f, lhs, rhs;
	wide_t vb, pv, am, s_vel, thr, b_new, f_w, g_sum, d_rnd, fwd_lin, fwd_w, pos_cur;
	q32_t  filt_new, v_rnd, v_new, pos_push;
	logic  keep, still;
	logic [1:0] push_ax;

	always_comb begin
		p56     = 56'(prod_q);
		s_cur   = 56'(s_q[ax_q]);
		case (ax_q)
			2'd0:    cal_cur = 56'(cfg.cal_x);
			2'd1:    cal_cur = 56'(cfg.cal_y);
			default: cal_cur = 56'(cfg.cal_z);
		endcase

		sum_f    = acc_q + (p56 <<< 16) + 56'sd32768;
		filt_new = sat32(sum_f >>> 16);

		lhs = mag(s_cur) <<< 8;
		rhs = mag(p56);
		case (ax_q)
			2'd0:    keep = lhs >= rhs;
			2'd1:    keep = ((lhs <<< 2) + lhs) >= (rhs <<< 2);
			default: keep = ((lhs <<< 2) + lhs) >= rhs;
		endcase

		vb    = mag(56'(vel_q[ax_q]));
		pv    = 56'(prev_q[ax_q]);
		am    = mag(56'(gat_q[ax_q]));
		s_vel = vb + pv + ((am - pv) >>> 1);
		thr   = $signed({25'd0, cfg.still_tolerance, 16'd0});
		still = am < thr;
		v_rnd = sat32((p56 + 56'sd32768) >>> 16);
		v_new = still ? 32'sd0 : v_rnd;
		b_new = still ? 56'sd0 : b_q;
		f_w   = b_new + ((mag(56'(v_new)) - b_new) >>> 1);

		g_sum = 56'(force_q[0]) + 56'(force_q[1]);
		d_rnd = (p56 + 56'sd32768) >>> 16;
		case (step_q)
			ST_C7:   push_ax = 2'd0;
			ST_C8:   push_ax = 2'd1;
			default: push_ax = 2'd2;
		endcase
		pos_cur  = 56'(pos_q[push_ax]);
		pos_push = sat32(pos_cur + d_rnd);

		case (step_q)
			ST_C2:   fwd_lin = (acc_q - p56) <<< 1;
			ST_C4:   fwd_lin = 56'sd268435456 - ((acc_q + p56) <<< 1);
			default: fwd_lin = (acc_q + p56) <<< 1;
		endcase
		fwd_w = (fwd_lin + 56'sd2048) >>> 12;

		case (step_q)
			ST_A0: begin
				mul_a = 35'(filt_q[ax_q]);
				mul_b = K_KEEP;
			end
			ST_A1: begin
				mul_a = 35'(s_q[ax_q]);
				mul_b = K_NEW;
			end
			ST_A2: begin
				mul_a = cal_cur[34:0];
				mul_b = $signed({6'd0, cfg.gate_strength});
			end
			ST_B0: begin
				mul_a = s_vel[34:0];
				mul_b = K_DT;
			end
			ST_C0: begin
				mul_a = 35'(qx_q);
				mul_b = 22'(qy_q);
			end
			ST_C1: begin
				mul_a = 35'(qw_q);
				mul_b = 22'(qz_q);
			end
			ST_C2: begin
				mul_a = 35'(qx_q);
				mul_b = 22'(qx_q);
			end
			ST_C3: begin
				mul_a = 35'(qz_q);
				mul_b = 22'(qz_q);
			end
			ST_C4: begin
				mul_a = 35'(qw_q);
				mul_b = 22'(qx_q);
			end
			ST_C5: begin
				mul_a = 35'(qy_q);
				mul_b = 22'(qz_q);
			end
			ST_C6: begin
				mul_a = g_sum[34:0];
				mul_b = fwd_q[0];
			end
			ST_C7: begin
				mul_a = g_sum[34:0];
				mul_b = fwd_q[1];
			end
			ST_C8: begin
				mul_a = g_sum[34:0];
				mul_b = fwd_q[2];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			ax_q   <= 2'd0;
			for (int i = 0; i < 3; i++) begin
				filt_q[i] <= '0;
				gat_q[i]  <= '0;
				vel_q[i]  <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (start) begin
						s_q[0] <= sample.accel_x;
						s_q[1] <= sample.accel_y;
						s_q[2] <= sample.accel_z;
						qw_q   <= sample.quat_w;
						qx_q   <= sample.quat_x;
						qy_q   <= sample.quat_y;
						qz_q   <= sample.quat_z;
						ax_q   <= 2'd0;
						step_q <= ST_A0;
					end
				end
				ST_A0: step_q <= ST_A1;
				ST_A1: begin
					acc_q  <= p56;
					step_q <= ST_A2;
				end
				ST_A2: begin
					filt_q[ax_q] <= filt_new;
					fn_q         <= filt_new;
					step_q       <= ST_A3;
				end
				ST_A3: begin
					// The previous gated value is kept for the velocity pass.
					prev_q[ax_q] <= gat_q[ax_q];
					gat_q[ax_q]  <= keep ? fn_q : 32'sd0;
					if (ax_q == 2'd2) begin
						ax_q   <= 2'd0;
						step_q <= ST_B0;
					end else begin
						ax_q   <= ax_q + 2'd1;
						step_q <= ST_A0;
					end
				end
				ST_B0: begin
					b_q    <= vb;
					step_q <= ST_B1;
				end
				ST_B1: begin
					vel_q[ax_q]   <= v_new;
					force_q[ax_q] <= f_w[32:0];
					if (ax_q == 2'd2) begin
						ax_q   <= 2'd0;
						step_q <= ST_C0;
					end else begin
						ax_q   <= ax_q + 2'd1;
						step_q <= ST_B0;
					end
				end
				ST_C0: begin
					pos_q[2] <= sat32(56'(pos_q[2]) + 56'(force_q[2]));
					step_q   <= ST_C1;
				end
				ST_C1: begin
					acc_q  <= p56;
					step_q <= ST_C2;
				end
				ST_C2: begin
					fwd_q[0] <= fwd_w[21:0];
					step_q   <= ST_C3;
				end
				ST_C3: begin
					acc_q  <= p56;
					step_q <= ST_C4;
				end
				ST_C4: begin
					fwd_q[1] <= fwd_w[21:0];
					step_q   <= ST_C5;
				end
				ST_C5: begin
					acc_q  <= p56;
					step_q <= ST_C6;
				end
				ST_C6: begin
					fwd_q[2] <= fwd_w[21:0];
					step_q   <= ST_C7;
				end
				ST_C7, ST_C8, ST_C9: begin
					pos_q[push_ax] <= pos_push;
					step_q         <= (step_q == ST_C9) ? ST_OUT : step_q + 5'd1;
				end
				ST_OUT: begin
					if (out_free) begin
						step_q <= ST_IDLE;
					end
				end
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		stat.busy = step_q != ST_IDLE;
		stat.done = (step_q == ST_OUT) && out_free;
	end

	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];

endmodule

`default_nettype wire

/* rtl/imu_dead_reckoning_step.sv */
// Usage
// Input stream (s_t*): one request per sample, acceleration x/y/z and quaternion w/x/y/z.
// Output stream (m_t*): one request per sample, the new position x/y/z in Q16.16.
// Configuration channel (cfg_*): register index and data, always ready; write it only
// while no sample is in flight.
// A sample is taken when the block is idle; s_tready then stays low for the whole step.
// The step runs on one shared multiplier under a sequencer: filter and gate (states A0-A3
// per axis), velocity (B0-B1 per axis), forward vector and position (C0-C9), and a final
// state that hands over the result; the block takes a new sample only after its step is
// back in the idle state.
// The result sits in an output register; the next sample is accepted while it waits.
// If the receiver stalls, the following step finishes its arithmetic and then holds
// in its last state until the output register is free.
// Reset clears all filter, velocity and position state and loads the register defaults
// (gate strength 1.0, everything else zero).
// Depends on imudr_pkg and imudr_core.
`default_nettype none

module imu_dead_reckoning_step import imudr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, 16 bits each
	input  wire logic [111:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, pos_z, 32 bits each
	output logic [95:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	cfg_t    cfg_q;
	sample_t sample;
	stat_t   stat;
	q32_t    pos_x, pos_y, pos_z;
	logic    out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_x           <= '0;
			cfg_q.cal_y           <= '0;
			cfg_q.cal_z           <= '0;
			cfg_q.gate_strength   <= 16'd256;
			cfg_q.still_tolerance <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAL_X:     cfg_q.cal_x           <= cfg_data;
				CFG_CAL_Y:     cfg_q.cal_y           <= cfg_data;
				CFG_CAL_Z:     cfg_q.cal_z           <= cfg_data;
				CFG_GATE_STR:  cfg_q.gate_strength   <= cfg_data;
				CFG_STILL_TOL: cfg_q.still_tolerance <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sample.accel_x = s_tdata[15:0];
		sample.accel_y = s_tdata[31:16];
		sample.accel_z = s_tdata[47:32];
		sample.quat_w  = s_tdata[63:48];
		sample.quat_x  = s_tdata[79:64];
		sample.quat_y  = s_tdata[95:80];
		sample.quat_z  = s_tdata[111:96];
	end

	assign s_tready = !stat.busy;
	assign out_free = !m_tvalid || m_tready;

	imudr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && s_tready),
		.sample   (sample),
		.cfg      (cfg_q),
		.out_free (out_free),
		.stat     (stat),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (stat.done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			m_tdata <= {pos_z, pos_y, pos_x};
		end
	end

endmodule

`default_nettype wire

/* rtl/imudr_chk.sv */
// Port-level checker for the dead-reckoning step, attached by the bind at the end.
// Depends only on the top level's ports.
`default_nettype none

module imudr_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [95:0]  m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Once a sample is taken the block stays busy on it.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a request");

	// A new result never appears in the cycle after a sample is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

	// A new result only comes out of a busy step.
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a step in progress");

endmodule

bind imu_dead_reckoning_step imudr_chk u_chk (.*);

`default_nettype wire

/* test/tb_imu_dead_reckoning_step.sv */
// Self-checking testbench for imu_dead_reckoning_step: drives sample requests and
// configuration writes, predicts each position result and compares field by field.
// Depends on imudr_pkg and the imu_dead_reckoning_step RTL.
`default_nettype none

module tb_imu_dead_reckoning_step;
	timeunit 1ns;
	timeprecision 1ps;
	import imudr_pkg::*;

	localparam int LATENCY = 40;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [111:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	imu_dead_reckoning_step uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Predictor state and configuration.
	longint filt[3], gated[3], vel[3], pos[3];
	longint p_cal[3], p_strength, p_tol;

	logic [111:0] pending_samples[$];
	position_t expected_positions[$];
	int send_idle_pct = 19;
	int recv_idle_pct = 71;
	bit hold_samples = 1'b0;
	bit in_taken = 1'b0;
	int mismatches = 0;
	longint cycles = 0;

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic position_t predict_position(logic [111:0] d);
		longint s[3], prev[3], acc[3], base[3], push_f[3], fwd[3];
		longint qw, qx, qy, qz, g, lhs, rhs, f, sum, v, thr;
		bit keep;
		position_t r;
		for (int i = 0; i < 3; i++) s[i] = longint'($signed(d[16*i +: 16]));
		qw = longint'($signed(d[48 +: 16]));
		qx = longint'($signed(d[64 +: 16]));
		qy = longint'($signed(d[80 +: 16]));
		qz = longint'($signed(d[96 +: 16]));
		thr = p_tol * 65536;
		for (int i = 0; i < 3; i++) begin
			lhs = absval(s[i]) * 256;
			rhs = absval(p_cal[i] * p_strength);
			f = clamp32(floor_shift(58982 * filt[i] + 6554 * (s[i] * 65536) + 32768, 16));
			filt[i] = f;
			if (i == 0) keep = lhs >= rhs;
			else if (i == 1) keep = lhs * 5 >= rhs * 4;
			else keep = lhs * 5 >= rhs;
			prev[i] = gated[i];
			acc[i] = keep ? f : 0;
			gated[i] = acc[i];
		end
		for (int i = 0; i < 3; i++) begin
			base[i] = absval(vel[i]);
			sum = base[i] + prev[i] + floor_shift(absval(acc[i]) - prev[i], 1);
			v = clamp32(floor_shift(sum * 6554 + 32768, 16));
			if (absval(acc[i]) < thr) begin
				v = 0;
				base[i] = 0;
			end
			vel[i] = v;
			push_f[i] = base[i] + floor_shift(absval(v) - base[i], 1);
		end
		pos[2] = clamp32(pos[2] + push_f[2]);
		fwd[0] = floor_shift(2 * (qx * qy - qw * qz) + 2048, 12);
		fwd[1] = floor_shift((64'sd1 << 28) - 2 * (qx * qx + qz * qz) + 2048, 12);
		fwd[2] = floor_shift(2 * (qw * qx + qy * qz) + 2048, 12);
		g = push_f[0] + push_f[1];
		for (int i = 0; i < 3; i++)
			pos[i] = clamp32(pos[i] + floor_shift(g * fwd[i] + 32768, 16));
		r.pos_x = pos[0][31:0];
		r.pos_y = pos[1][31:0];
		r.pos_z = pos[2][31:0];
		return r;
	endfunction

	// Driver: presents queued samples and sets m_tready, changing inputs on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				// request still waiting, hold it
			end else if (pending_samples.size() > 0 && !hold_samples
					&& $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= pending_samples.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on acceptance and checks results at the rising edge.
	always @(posedge clk) begin
		position_t got, want;
		cycles <= cycles + 1;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			expected_positions.push_back(predict_position(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_positions.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %h", m_tdata);
			end else begin
				want = expected_positions.pop_front();
				if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
						|| got.pos_z !== want.pos_z) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("position mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
							want.pos_x, want.pos_y, want.pos_z,
							got.pos_x, got.pos_y, got.pos_z);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("** imu_dead_reckoning_step: FAILED **");
			$finish;
		end
	end

	task automatic write_register(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CAL_X: p_cal[0] = longint'($signed(value));
			CFG_CAL_Y: p_cal[1] = longint'($signed(value));
			CFG_CAL_Z: p_cal[2] = longint'($signed(value));
			CFG_GATE_STR: p_strength = longint'(value);
			CFG_STILL_TOL: p_tol = longint'(value[14:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_samples.size() > 0 || s_tvalid || expected_positions.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [15:0] random_quat();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic logic [111:0] random_sample();
		logic [111:0] d;
		for (int i = 0; i < 3; i++)
			d[16*i +: 16] = ($urandom_range(3) == 0) ? 16'($urandom_range(200))
				: 16'($urandom);
		for (int i = 3; i < 7; i++) d[16*i +: 16] = random_quat();
		return d;
	endfunction

	task automatic queue_random(int count);
		repeat (count) pending_samples.push_back(random_sample());
	endtask

	// Random register setting; small X and Z calibrations so the gate both passes and blocks.
	task automatic random_config();
		write_register(CFG_CAL_X, 16'($signed($urandom_range(4000)) - 2000));
		write_register(CFG_CAL_Y, 16'($urandom));
		write_register(CFG_CAL_Z, 16'($signed($urandom_range(4000)) - 2000));
		write_register(CFG_GATE_STR, 16'($urandom_range(512)));
		write_register(CFG_STILL_TOL, 16'($urandom_range(300)));
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			filt[i] = 0; gated[i] = 0; vel[i] = 0; pos[i] = 0; p_cal[i] = 0;
		end
		p_strength = 256;
		p_tol = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, identity and non-unit quaternions, gate on default regs.
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384,
			16'h7FFF, 16'h7FFF, 16'h7FFF});
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384,
			16'h8000, 16'h8000, 16'h8000});
		pending_samples.push_back({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
			16'h7FFF, 16'h8000, 16'h7FFF});
		pending_samples.push_back({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			16'h8000, 16'h7FFF, 16'h8000});
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 16'h0001, 16'h0100});
		pending_samples.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'h1234, 16'h8000, 16'h0});
		drain_results();

		// Extreme register values: full calibration and strength, max tolerance.
		write_register(CFG_CAL_X, 16'h7FFF);
		write_register(CFG_CAL_Y, 16'h8000);
		write_register(CFG_CAL_Z, 16'h7FFF);
		write_register(CFG_GATE_STR, 16'hFFFF);
		write_register(CFG_STILL_TOL, 16'h7FFF);
		pending_samples.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
			16'h7FFF, 16'h8000, 16'h7FFF});
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0,
			16'h8000, 16'h7FFF, 16'h8000});
		drain_results();

		// Zero strength lets every axis pass; long saturating push.
		write_register(CFG_GATE_STR, 16'h0000);
		write_register(CFG_STILL_TOL, 16'h0000);
		repeat (12) pending_samples.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd16384,
			16'h7FFF, 16'h7FFF, 16'h7FFF});
		drain_results();

		random_config();
		queue_random(500);
		drain_results();

		send_idle_pct = 71;
		recv_idle_pct = 19;
		random_config();
		queue_random(250);
		// Let the block empty out completely in the middle of the phase.
		while (pending_samples.size() > 0) @(posedge clk);
		hold_samples = 1'b1;
		while (s_tvalid || expected_positions.size() > 0) @(posedge clk);
		hold_samples = 1'b0;
		queue_random(250);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_config();
		queue_random(270);
		drain_results();
		write_register(CFG_CAL_X, 16'h0000);
		write_register(CFG_CAL_Y, 16'h0000);
		write_register(CFG_CAL_Z, 16'h0000);
		write_register(CFG_GATE_STR, 16'h0100);
		queue_random(250);
		drain_results();

		if (mismatches == 0 && expected_positions.size() == 0) begin
			$display("** imu_dead_reckoning_step: PASSED **");
		end else begin
			$display("** imu_dead_reckoning_step: FAILED **");
		end
		$finish;
	end
endmodule

`default_nettype wire
